[hdl/msort_pkg.sv]
// ----------------------------------------------------------------------------
// msort_pkg: shared types and constants of the merge sorter
// State encoding of the sequencer, bus widths and compare mode bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

package msort_pkg;

    // width of the key on the stream buses
    localparam int unsigned DATA_W = 32;

    // compare mode register
    localparam int unsigned MODE_W         = 2;
    localparam int unsigned CMP_SIGNED_BIT = 0;
    localparam int unsigned CMP_DESC_BIT   = 1;

    // sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP,
        S_READ,
        S_MERGE,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

endpackage

`default_nettype wire

[hdl/msort_ram.sv]
// ----------------------------------------------------------------------------
// msort_ram: generic simple dual-port RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic      [WIDTH-1:0]           o_rdata_a,
    output logic      [WIDTH-1:0]           o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

[hdl/merge_sorter_top.sv]
// ----------------------------------------------------------------------------
// merge_sorter_top: run-based merge sorter
// Loads a run of keys, sorts it with bottom-up merge passes between two RAMs
// and streams the keys out in order.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s side): one key per beat, tlast marks the last key of a
//   run. Keys are taken at one per cycle while loading; keys beyond
//   MAX_ITEMS are dropped and the run is flagged.
//   Output stream (m side): one sorted key per beat, tlast on the last key
//   of the run, tuser set on every beat of a run that lost keys.
//   compare_mode (i_cfg_we/i_cfg_wdata): bit0 signed keys, bit1 descending;
//   write it only between runs.
//   For a run of n keys: the load, then ceil(log2 n) merge passes, in
//   which each key takes a read of the two RAM heads (S_READ) and a
//   compare and write-back (S_MERGE), plus a setup (S_SETUP) per block
//   and per pass, then per key a RAM read (S_OUT_RD) and an output
//   register load (S_OUT_LD) on the output side.
//   Reset clears the load count and the mode register; RAM contents are
//   left as they are. A stalled receiver holds the output register and the
//   sequencer waits; the next run may start loading while the last sorted
//   key still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter_top #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [msort_pkg::DATA_W-1:0]  i_s_tdata,   // [31:0] key
    input  wire logic                          i_s_tlast,   // last
    // output stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [msort_pkg::DATA_W-1:0]  o_m_tdata,   // [31:0] sorted_key
    output logic                               o_m_tlast,   // final_res
    output logic                               o_m_tuser,   // [0] overflow
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [msort_pkg::MODE_W-1:0]  i_cfg_wdata  // compare_mode
);

    import msort_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] C_ONE   = CW'(1);
    localparam logic [SW-1:0] S_ONE   = SW'(1);

    // true when key a strictly precedes key b under the given mode
    function automatic logic comes_first(
        input logic [KEY_WIDTH-1:0] a,
        input logic [KEY_WIDTH-1:0] b,
        input logic [MODE_W-1:0]    mode
    );
        logic [KEY_WIDTH-1:0] ta;
        logic [KEY_WIDTH-1:0] tb;
        ta = a ^ {mode[CMP_SIGNED_BIT], {(KEY_WIDTH-1){1'b0}}};
        tb = b ^ {mode[CMP_SIGNED_BIT], {(KEY_WIDTH-1){1'b0}}};
        return mode[CMP_DESC_BIT] ? (tb < ta) : (ta < tb);
    endfunction

    // registers
    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_dropped, n_dropped;
    logic [CW-1:0]         r_n, n_n;
    logic                  r_src, n_src;
    logic [SW-1:0]         r_w, n_w;
    logic [SW-1:0]         r_b, n_b;
    logic [SW-1:0]         r_mid, n_mid;
    logic [SW-1:0]         r_end, n_end;
    logic [SW-1:0]         r_pl, n_pl;
    logic [SW-1:0]         r_pr, n_pr;
    logic [SW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_W-1:0]     r_out_data, n_out_data;
    logic                  r_out_last, n_out_last;
    logic                  r_out_ovf, n_out_ovf;

    // combinational
    logic                  w_in_beat;
    logic                  w_out_beat;
    logic                  w_load_we;
    logic                  w_merge_we;
    logic [KEY_WIDTH-1:0]  w_key_in;
    logic [KEY_WIDTH-1:0]  w_head_l;
    logic [KEY_WIDTH-1:0]  w_head_r;
    logic                  w_take_left;
    logic [KEY_WIDTH-1:0]  w_merge_key;
    logic [KEY_WIDTH-1:0]  w_src_key;
    logic [DATA_W-1:0]     w_key_out;
    logic [SW-1:0]         w_n_ext;
    logic [SW-1:0]         w_sum_mid;
    logic [SW-1:0]         w_sum_end;
    logic [CW-1:0]         w_count_inc;

    // ram ports
    logic                  w_ram0_we;
    logic                  w_ram1_we;
    logic [AW-1:0]         w_ram0_waddr;
    logic [KEY_WIDTH-1:0]  w_ram0_wdata;
    logic [AW-1:0]         w_raddr_a;
    logic [AW-1:0]         w_raddr_b;
    logic [KEY_WIDTH-1:0]  w_rd0_a, w_rd0_b, w_rd1_a, w_rd1_b;

    // key width conversion between bus and store
    if (KEY_WIDTH > DATA_W) begin : g_wide
        assign w_key_in  = {{(KEY_WIDTH-DATA_W){1'b0}}, i_s_tdata};
        assign w_key_out = w_src_key[DATA_W-1:0];
    end else if (KEY_WIDTH == DATA_W) begin : g_same
        assign w_key_in  = i_s_tdata;
        assign w_key_out = w_src_key;
    end else begin : g_narrow
        assign w_key_in  = i_s_tdata[KEY_WIDTH-1:0];
        assign w_key_out = {{(DATA_W-KEY_WIDTH){1'b0}}, w_src_key};
    end

    // handshakes
    assign o_s_tready = (r_state == S_LOAD);
    assign w_in_beat  = i_s_tvalid && o_s_tready;
    assign w_out_beat = r_out_valid && i_m_tready;

    // block bounds and counts
    assign w_n_ext     = {2'b00, r_n};
    assign w_sum_mid   = r_b + r_w;
    assign w_sum_end   = r_b + {r_w[SW-2:0], 1'b0};
    assign w_count_inc = r_count + C_ONE;

    // merge heads come from whichever ram is the source of this pass
    assign w_head_l    = r_src ? w_rd1_a : w_rd0_a;
    assign w_head_r    = r_src ? w_rd1_b : w_rd0_b;
    assign w_src_key   = w_head_l;
    // left wins while it has keys, if right is spent or left strictly precedes
    assign w_take_left = (r_pl < r_mid) &&
                         ((r_pr >= r_end) || comes_first(w_head_l, w_head_r, r_mode));
    assign w_merge_key = w_take_left ? w_head_l : w_head_r;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_beat && i_s_tlast) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_w >= w_n_ext) begin
                    n_state = S_OUT_RD;
                end else if (r_b < w_n_ext) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (r_k + S_ONE == r_end) begin
                    n_state = S_SETUP;
                end else begin
                    n_state = S_READ;
                end
            end
            S_OUT_RD: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                if (r_idx + C_ONE == r_n) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_OUT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // ram control; source and destination rams never coincide, so no
    // read and write to the same entry can overlap
    always_comb begin
        w_load_we    = w_in_beat && (r_count < CNT_MAX);
        w_merge_we   = (r_state == S_MERGE);
        w_ram0_we    = w_load_we || (w_merge_we && r_src);
        w_ram1_we    = w_merge_we && !r_src;
        w_ram0_waddr = w_load_we ? r_count[AW-1:0] : r_k[AW-1:0];
        w_ram0_wdata = w_load_we ? w_key_in : w_merge_key;
        w_raddr_a    = (r_state == S_READ) ? r_pl[AW-1:0] : r_idx[AW-1:0];
        w_raddr_b    = r_pr[AW-1:0];
    end

    // datapath next values
    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_n         = r_n;
        n_src       = r_src;
        n_w         = r_w;
        n_b         = r_b;
        n_mid       = r_mid;
        n_end       = r_end;
        n_pl        = r_pl;
        n_pr        = r_pr;
        n_k         = r_k;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !w_out_beat;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        case (r_state)
            // load beat, drop once the store is full
            S_LOAD: begin
                if (w_in_beat) begin
                    if (r_count < CNT_MAX) begin
                        n_count = w_count_inc;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_n   = (r_count < CNT_MAX) ? w_count_inc : r_count;
                        n_src = 1'b0;
                        n_w   = S_ONE;
                        n_b   = '0;
                    end
                end
            end
            // open the next block, close the pass, or end the sort for output
            S_SETUP: begin
                if (r_w >= w_n_ext) begin
                    n_idx = '0;
                end else if (r_b >= w_n_ext) begin
                    n_w   = {r_w[SW-2:0], 1'b0};
                    n_b   = '0;
                    n_src = !r_src;
                end else begin
                    n_mid = (w_sum_mid < w_n_ext) ? w_sum_mid : w_n_ext;
                    n_end = (w_sum_end < w_n_ext) ? w_sum_end : w_n_ext;
                    n_pl  = r_b;
                    n_pr  = (w_sum_mid < w_n_ext) ? w_sum_mid : w_n_ext;
                    n_k   = r_b;
                end
            end
            // one merged key written to the destination
            S_MERGE: begin
                n_k = r_k + S_ONE;
                if (w_take_left) begin
                    n_pl = r_pl + S_ONE;
                end else begin
                    n_pr = r_pr + S_ONE;
                end
                if (r_k + S_ONE == r_end) begin
                    n_b = r_end;
                end
            end
            // output register load
            S_OUT_LD: begin
                n_out_valid = 1'b1;
                n_out_data  = w_key_out;
                n_out_last  = (r_idx + C_ONE == r_n);
                n_out_ovf   = r_dropped;
                n_idx       = r_idx + C_ONE;
                if (r_idx + C_ONE == r_n) begin
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_mode      <= '0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_src       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_src       <= n_src;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    // pass counters and output payload
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_w        <= n_w;
        r_b        <= n_b;
        r_mid      <= n_mid;
        r_end      <= n_end;
        r_pl       <= n_pl;
        r_pr       <= n_pr;
        r_k        <= n_k;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    // ping-pong key stores
    msort_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (MAX_ITEMS)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (w_ram0_we),
        .i_waddr   (w_ram0_waddr),
        .i_wdata   (w_ram0_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd0_a),
        .o_rdata_b (w_rd0_b)
    );

    msort_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (MAX_ITEMS)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (w_ram1_we),
        .i_waddr   (r_k[AW-1:0]),
        .i_wdata   (w_merge_key),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd1_a),
        .o_rdata_b (w_rd1_b)
    );

    // outputs
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_ovf;

endmodule

`default_nettype wire

[hdl/msort_chk.sv]
// ----------------------------------------------------------------------------
// msort_chk: port-level checks of the merge sorter
// Watches the stream ports for sequencing and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module msort_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          i_s_tlast,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [msort_pkg::DATA_W-1:0]  o_m_tdata,
    input wire logic                          o_m_tlast,
    input wire logic                          o_m_tuser
);

    import msort_pkg::*;

    // idle and empty after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("not idle after reset");

    // accepted last key of a run closes the input
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input still open after last beat");

    // no loading while a run is still being emitted
    a_emit_blocks_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input open mid-run on output");

    // stalled output beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("output changed under stall");

endmodule

bind merge_sorter_top msort_chk u_msort_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

[bench/merge_sorter_top_tb.sv]
// ----------------------------------------------------------------------------
// merge_sorter_top_tb: self-checking bench for the run-based merge sorter
// Streams runs of keys under every compare mode, including full runs and
// runs that lose keys past capacity. A local sort of each run gives the
// expected beats, and every output beat is checked field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter_top_tb;

    import msort_pkg::*;

    localparam int RUN_CAP    = 64;
    localparam int TOTAL_KEYS = 430;
    localparam int STALL_MAX  = 20000;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_PCT   = 31;

    // compare mode register codes
    localparam logic [MODE_W-1:0] MODE_UNS_ASC  = 2'b00;
    localparam logic [MODE_W-1:0] MODE_SGN_ASC  = 2'b01;
    localparam logic [MODE_W-1:0] MODE_UNS_DESC = 2'b10;
    localparam logic [MODE_W-1:0] MODE_SGN_DESC = 2'b11;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata   = '0;    // [31:0] key
    logic              i_s_tlast   = 1'b0;  // last
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;           // [31:0] sorted_key
    logic              o_m_tlast;           // final_res
    logic              o_m_tuser;           // [0] overflow
    logic              i_cfg_we    = 1'b0;
    logic [MODE_W-1:0] i_cfg_wdata = '0;    // compare_mode

    int keys_sent    = 0;
    int beats_seen   = 0;
    int stall_cycles = 0;

    // sorts each finished run and holds the beats still due from the block
    class run_sort_checker;
        typedef struct packed {
            logic [DATA_W-1:0] key;
            logic              tail;
            logic              ovf;
        } t_sorted_beat;

        logic [MODE_W-1:0] mode = MODE_UNS_ASC;
        logic [DATA_W-1:0] run_keys[$];
        bit                run_dropped = 1'b0;
        t_sorted_beat      sorted_due[$];
        int                errors = 0;

        // true when key a goes strictly ahead of key b
        function bit precedes(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            if (mode[CMP_SIGNED_BIT]) begin
                a[DATA_W-1] = ~a[DATA_W-1];
                b[DATA_W-1] = ~b[DATA_W-1];
            end
            if (mode[CMP_DESC_BIT])
                return b < a;
            return a < b;
        endfunction

        // note one accepted input beat, predict the run once it closes
        function void take_key(logic [DATA_W-1:0] key, logic tail);
            logic [DATA_W-1:0] x;
            int                j;
            t_sorted_beat      beat;
            if (run_keys.size() < RUN_CAP)
                run_keys.push_back(key);
            else
                run_dropped = 1'b1;
            if (!tail)
                return;
            // tied keys are equal bit for bit, so tie order never shows
            for (int i = 1; i < run_keys.size(); i++) begin
                x = run_keys[i];
                j = i;
                while (j > 0 && precedes(x, run_keys[j-1])) begin
                    run_keys[j] = run_keys[j-1];
                    j--;
                end
                run_keys[j] = x;
            end
            foreach (run_keys[i]) begin
                beat.key  = run_keys[i];
                beat.tail = (i == run_keys.size() - 1);
                beat.ovf  = run_dropped;
                sorted_due.push_back(beat);
            end
            run_keys.delete();
            run_dropped = 1'b0;
        endfunction

        // compare one output beat with the oldest one due
        function void match_sorted(logic [DATA_W-1:0] key, logic tail, logic ovf);
            t_sorted_beat want;
            if (sorted_due.size() == 0) begin
                $error("sorted beat with none due: key %h last %b ovf %b", key, tail, ovf);
                errors++;
                return;
            end
            want = sorted_due.pop_front();
            if (key !== want.key) begin
                $error("sorted_key: expected %h, got %h", want.key, key);
                errors++;
            end
            if (tail !== want.tail) begin
                $error("final_res: expected %b, got %b", want.tail, tail);
                errors++;
            end
            if (ovf !== want.ovf) begin
                $error("overflow: expected %b, got %b", want.ovf, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return sorted_due.size();
        endfunction
    endclass

    run_sort_checker sorter_chk = new;

    merge_sorter_top #(
        .MAX_ITEMS (RUN_CAP),
        .KEY_WIDTH (DATA_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // random key: full range, clustered ties, around the sign edge, near max
    function automatic logic [DATA_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            3:       return $urandom_range(0, 7);
            4:       return 32'h7FFF_FFFC + $urandom_range(0, 7);
            5:       return 32'hFFFF_FFF8 | $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // offer one key beat, with random gaps outside the calm stretch
    task automatic send_key(logic [DATA_W-1:0] key, logic tail);
        bit calm;
        calm = (keys_sent >= 180 && keys_sent < 280);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        i_s_tlast  <= tail;
        do @(posedge i_clk); while (!o_s_tready);
        sorter_chk.take_key(key, tail);
        keys_sent++;
    endtask

    task automatic send_run(int len);
        for (int i = 0; i < len; i++)
            send_key(rand_key(), i == len - 1);
    endtask

    // mode change only once the block has drained
    task automatic write_mode(logic [MODE_W-1:0] m);
        i_s_tvalid <= 1'b0;
        while (sorter_chk.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sorter_chk.mode = m;
    endtask

    // receiver: random stalls, one long hold-off, beat checking
    initial begin
        bit held;
        bit calm;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && beats_seen >= 100) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            calm = (beats_seen >= 150 && beats_seen < 260);
            i_m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                sorter_chk.match_sorted(o_m_tdata, o_m_tlast, o_m_tuser);
                beats_seen++;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        while (stall_cycles < STALL_MAX) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("merge_sorter_top_tb: errors");
        $finish;
    end

    // stimulus
    initial begin
        logic [MODE_W-1:0] phase_modes[4];
        logic [DATA_W-1:0] edge_keys[5];
        int                first_len[4];
        int                phase_quota;
        int                phase_start;
        int                pick;
        phase_modes = '{MODE_SGN_DESC, MODE_UNS_ASC, MODE_SGN_ASC, MODE_UNS_DESC};
        // extremes of both orders plus a tie
        edge_keys   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                        32'hFFFF_FFFF, 32'h8000_0000};
        // overflow runs (last key dropped too), an exactly full run
        first_len   = '{66, 65, 64, 0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single-key run, then the edge run under every mode
        write_mode(MODE_UNS_ASC);
        send_key(32'hA5A5_5A5A, 1'b1);
        for (int m = 0; m < 4; m++) begin
            write_mode(m[MODE_W-1:0]);
            foreach (edge_keys[i])
                send_key(edge_keys[i], i == 4);
        end

        // random phases, one per mode
        phase_quota = (TOTAL_KEYS - keys_sent) / 4;
        for (int p = 0; p < 4; p++) begin
            write_mode(phase_modes[p]);
            phase_start = keys_sent;
            if (first_len[p] > 0)
                send_run(first_len[p]);
            while (keys_sent - phase_start < phase_quota) begin
                pick = $urandom_range(0, 29);
                if (pick == 0)
                    send_run($urandom_range(65, 68));
                else if (pick == 1)
                    send_run(RUN_CAP);
                else
                    send_run($urandom_range(1, 12));
            end
        end

        // drain and settle
        i_s_tvalid <= 1'b0;
        while (sorter_chk.pending() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sorter_chk.errors == 0)
            $display("merge_sorter_top_tb: clean");
        else
            $display("merge_sorter_top_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
